// ----- rtl/core/dual_table_rolling_hash_assert.svh -----
// Assertion macros used by the checker file.
`ifndef DUAL_TABLE_ROLLING_HASH_ASSERT_SVH
`define DUAL_TABLE_ROLLING_HASH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRH_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("drh assertion failed");

// Next-cycle implication, not disabled by reset.
`define DRH_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("drh assertion failed");

`endif

// ----- rtl/core/drh_pkg.sv -----
package drh_pkg;

  localparam int HASH_W    = 32;
  localparam int ENTRIES   = 256;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int ROT_W     = $clog2(HASH_W);
  localparam int WIN_W     = 7;
  localparam int ADDR_W    = 4;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_FEED  = 2'd2;
  localparam logic [1:0] OP_ROLL  = 2'd3;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_MASK   = 2'd2;

  localparam logic [WIN_W-1:0]  WINDOW_RESET = 7'd10;
  localparam logic [ROT_W-1:0]  STEP_RESET   = 5'd1;
  localparam logic [HASH_W-1:0] MASK_RESET   = '1;
  localparam logic [WIN_W-1:0]  FED_MAX      = '1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic              table_select;
    logic [IDX_W-1:0]  table_index;
    logic [31:0]       table_word;
    logic [IDX_W-1:0]  add_byte;
    logic [IDX_W-1:0]  remove_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] first_hash;
    logic [31:0] second_hash;
    logic        status;
  } out_t;

  typedef struct packed {
    logic [WIN_W-1:0]  window_size;
    logic [ROT_W-1:0]  rotate_step;
    logic [HASH_W-1:0] address_mask;
  } cfg_t;

  typedef struct packed {
    logic             fire;
    logic             clr;
    logic             feed;
    logic             roll;
    logic [ROT_W-1:0] step;
    logic [ROT_W-1:0] off;
  } lane_ctl_t;

  function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] x,
                                            input logic [ROT_W-1:0] r);
    logic [2*HASH_W-1:0] tmp;
    tmp = {x, x} << r;
    return tmp[2*HASH_W-1:HASH_W];
  endfunction

endpackage

// ----- rtl/core/drh_cfg.sv -----
module drh_cfg
  import drh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic       wr;
  logic [1:0] idx;

  assign idx        = cfg_paddr[ADDR_W-1:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_WINDOW: cfg_nxt.window_size  = cfg_pwdata[WIN_W-1:0];
        REG_STEP:   cfg_nxt.rotate_step  = cfg_pwdata[ROT_W-1:0];
        REG_MASK:   cfg_nxt.address_mask = cfg_pwdata[HASH_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WINDOW: cfg_prdata = {{(32-WIN_W){1'b0}}, cfg_r.window_size};
      REG_STEP:   cfg_prdata = {{(32-ROT_W){1'b0}}, cfg_r.rotate_step};
      REG_MASK:   cfg_prdata = cfg_r.address_mask;
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_size  <= WINDOW_RESET;
      cfg_r.rotate_step  <= STEP_RESET;
      cfg_r.address_mask <= MASK_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/core/drh_table.sv -----
module drh_table
  import drh_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [HASH_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_idx_a,
  input  logic [IDX_W-1:0]  rd_idx_b,
  output logic [HASH_W-1:0] rd_a,
  output logic [HASH_W-1:0] rd_b
);

  logic [HASH_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem[rd_idx_a];
      rd_b <= mem[rd_idx_b];
    end
  end

endmodule

// ----- rtl/core/drh_lane.sv -----
module drh_lane
  import drh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lane_ctl_t         ctl,
  input  logic [HASH_W-1:0] t_add,
  input  logic [HASH_W-1:0] t_rem,
  output logic [HASH_W-1:0] hash_nxt
);

  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] stepped;

  assign stepped = rotl(hash_r, ctl.step) ^ t_add;

  always_comb begin
    hash_nxt = hash_r;
    if (ctl.clr) begin
      hash_nxt = '0;
    end else if (ctl.feed) begin
      hash_nxt = stepped;
    end else if (ctl.roll) begin
      // drop the leaving byte, rotated to where it sits after window_size steps
      hash_nxt = stepped ^ rotl(t_rem, ctl.off);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
    end else if (ctl.fire) begin
      hash_r <= hash_nxt;
    end
  end

endmodule

// ----- rtl/core/dual_table_rolling_hash.sv -----
// A request waits in stage 1 for its registered table words, then the hash update is registered
// into the output register. Throughput: one request per cycle while the output is not stalled
// (out_ready low with a result held stops stage 1 and drops in_ready).
// Reset (rst_n low, synchronous): clears handshake state, both hashes, byte count, window flag
// and the config registers (window 10, step 1, mask all ones). Tables are not cleared.
module dual_table_rolling_hash
  import drh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cfg_t              cfg;
  logic              accept, s1_go, fire;
  logic              s1_v_r, s1_v_nxt;
  logic [1:0]        s1_op_r;
  logic              out_v_r, out_v_nxt;
  out_t              out_r, out_nxt;
  logic [WIN_W-1:0]  fed_r, fed_nxt;
  logic              full_r, full_nxt;
  logic [WIN_W+ROT_W-1:0] prod;
  lane_ctl_t         ctl;
  logic [HASH_W-1:0] t1_add, t1_rem, t2_add, t2_rem;
  logic [HASH_W-1:0] h1_nxt, h2_nxt;
  logic              wr_req;

  drh_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  assign s1_go    = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_go;
  assign accept   = in_valid && in_ready;
  assign fire     = s1_v_r && s1_go;
  assign wr_req   = accept && (in_data.opcode == OP_WRITE);

  drh_table u_tab1 (
    .clk, .wr_en(wr_req && !in_data.table_select), .wr_idx(in_data.table_index),
    .wr_data(in_data.table_word), .rd_en(accept), .rd_idx_a(in_data.add_byte),
    .rd_idx_b(in_data.remove_byte), .rd_a(t1_add), .rd_b(t1_rem)
  );

  drh_table u_tab2 (
    .clk, .wr_en(wr_req && in_data.table_select), .wr_idx(in_data.table_index),
    .wr_data(in_data.table_word), .rd_en(accept), .rd_idx_a(in_data.add_byte),
    .rd_idx_b(in_data.remove_byte), .rd_a(t2_add), .rd_b(t2_rem)
  );

  assign prod = {{WIN_W{1'b0}}, cfg.rotate_step} * {{ROT_W{1'b0}}, cfg.window_size};

  always_comb begin
    ctl.fire = fire;
    ctl.clr  = s1_op_r == OP_CLEAR;
    ctl.feed = s1_op_r == OP_FEED;
    ctl.roll = (s1_op_r == OP_ROLL) && full_r;
    ctl.step = cfg.rotate_step;
    ctl.off  = prod[ROT_W-1:0];
  end

  drh_lane u_lane1 (
    .clk, .rst_n, .ctl, .t_add(t1_add), .t_rem(t1_rem), .hash_nxt(h1_nxt)
  );

  drh_lane u_lane2 (
    .clk, .rst_n, .ctl, .t_add(t2_add), .t_rem(t2_rem), .hash_nxt(h2_nxt)
  );

  always_comb begin
    fed_nxt  = fed_r;
    full_nxt = full_r;
    if (ctl.clr) begin
      fed_nxt  = '0;
      full_nxt = 1'b0;
    end else if (ctl.feed) begin
      fed_nxt  = (fed_r == FED_MAX) ? fed_r : fed_r + 1'b1;
      full_nxt = full_r || (fed_nxt >= cfg.window_size);
    end
  end

  always_comb begin
    out_nxt.first_hash  = h1_nxt & cfg.address_mask;
    out_nxt.second_hash = h2_nxt & cfg.address_mask;
    out_nxt.status      = (s1_op_r == OP_ROLL) && !full_r;
  end

  assign s1_v_nxt  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
  assign out_v_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      fed_r   <= '0;
      full_r  <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (fire) begin
        fed_r  <= fed_nxt;
        full_r <= full_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r <= in_data.opcode;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/drh_checker.sv -----
`include "dual_table_rolling_hash_assert.svh"

module drh_checker
  import drh_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data,
  input logic cfg_pready
);

  `DRH_ASSERT_NEXT(a_out_hold, clk, rst_n && out_valid && !out_ready, out_valid)
  `DRH_ASSERT_NEXT(a_out_data_hold, clk, rst_n && out_valid && !out_ready, $stable(out_data))
  `DRH_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid)
  `DRH_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
  `DRH_ASSERT_NOW(a_pready, clk, rst_n, 1'b1, cfg_pready)

endmodule

bind dual_table_rolling_hash drh_checker u_drh_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_data, .cfg_pready
);

// ----- tb/tb_dual_table_rolling_hash.sv -----
`timescale 1ns / 1ps

module tb_dual_table_rolling_hash;
  import drh_pkg::*;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 180;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 600;
  localparam int SETTLE      = 4;

  typedef enum {DRAIN_FREE, DRAIN_MOSTLY, DRAIN_PERIODIC, DRAIN_SPARSE} drain_mode_e;

  typedef struct packed {
    in_t  req;
    logic typed;
    out_t want;
  } vector_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  dual_table_rolling_hash u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hash predictor state
  logic [31:0]      subst_a [ENTRIES];
  logic [31:0]      subst_b [ENTRIES];
  logic [31:0]      hash_a = '0;
  logic [31:0]      hash_b = '0;
  logic [WIN_W-1:0] fed_count = '0;
  logic             window_full = 1'b0;
  logic [WIN_W-1:0] cfg_window = WINDOW_RESET;
  logic [ROT_W-1:0] cfg_step = STEP_RESET;
  logic [31:0]      cfg_mask = MASK_RESET;

  // stimulus bookkeeping
  bit          written_a [ENTRIES];
  bit          written_b [ENTRIES];
  logic [7:0]  usable_bytes [$];
  logic [7:0]  fed_bytes [$];
  vector_t     directed_rows [$];
  out_t        expected_hashes [$];
  int          burst_left = 4;
  int          requests_accepted = 0;
  int          results_checked = 0;
  int          early_rolls = 0;
  int          input_stall_cycles = 0;
  int          mismatches = 0;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    if (n == 5'd0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  // applies one request to the predictor, returns the result it should produce
  function automatic out_t step_hashes(input in_t r);
    out_t             res;
    logic [11:0]      prod;
    logic [ROT_W-1:0] off;
    res.status = 1'b0;
    case (r.opcode)
      OP_WRITE: begin
        if (r.table_select) subst_b[r.table_index] = r.table_word;
        else subst_a[r.table_index] = r.table_word;
      end
      OP_CLEAR: begin
        hash_a = '0;
        hash_b = '0;
        fed_count = '0;
        window_full = 1'b0;
      end
      OP_FEED: begin
        hash_a = rotl32(hash_a, cfg_step) ^ subst_a[r.add_byte];
        hash_b = rotl32(hash_b, cfg_step) ^ subst_b[r.add_byte];
        if (fed_count != FED_MAX) fed_count = fed_count + 1'b1;
        if (fed_count >= cfg_window) window_full = 1'b1;
      end
      OP_ROLL: begin
        if (!window_full) begin
          res.status = 1'b1;
        end else begin
          prod = cfg_step * cfg_window;
          off = prod[ROT_W-1:0];
          hash_a = rotl32(hash_a, cfg_step) ^ subst_a[r.add_byte]
                   ^ rotl32(subst_a[r.remove_byte], off);
          hash_b = rotl32(hash_b, cfg_step) ^ subst_b[r.add_byte]
                   ^ rotl32(subst_b[r.remove_byte], off);
        end
      end
    endcase
    res.first_hash = hash_a & cfg_mask;
    res.second_hash = hash_b & cfg_mask;
    return res;
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic sel,
                                  input logic [7:0] idx, input logic [31:0] word,
                                  input logic [7:0] add, input logic [7:0] rem,
                                  input logic typed, input logic [31:0] fh,
                                  input logic [31:0] sh, input logic st);
    vector_t row;
    row.req.opcode = op;
    row.req.table_select = sel;
    row.req.table_index = idx;
    row.req.table_word = word;
    row.req.add_byte = add;
    row.req.remove_byte = rem;
    row.typed = typed;
    row.want.first_hash = fh;
    row.want.second_hash = sh;
    row.want.status = st;
    directed_rows.push_back(row);
  endfunction

  // only bytes whose entries exist in both tables may be hashed
  function automatic logic [7:0] pick_byte();
    return usable_bytes[$urandom_range(0, usable_bytes.size() - 1)];
  endfunction

  function automatic in_t rand_req(input logic [1:0] op);
    in_t r;
    r.opcode = op;
    r.table_select = 1'($urandom_range(0, 1));
    r.table_index = 8'($urandom_range(0, 255));
    r.table_word = $urandom();
    r.add_byte = 8'($urandom_range(0, 255));
    r.remove_byte = 8'($urandom_range(0, 255));
    if (op == OP_FEED || op == OP_ROLL) r.add_byte = pick_byte();
    if (op == OP_ROLL) r.remove_byte = pick_byte();
    return r;
  endfunction

  task automatic log_mismatch(input string what, input int unsigned idx,
                              input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("mismatch: item %0d %s got %h want %h", idx, what, got, want);
  endtask

  task automatic send_request(input in_t req, input logic typed, input out_t want);
    out_t predicted;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    predicted = step_hashes(req);
    expected_hashes.push_back(typed ? want : predicted);
    requests_accepted++;
    case (req.opcode)
      OP_WRITE: begin
        if (req.table_select) begin
          if (!written_b[req.table_index]) begin
            written_b[req.table_index] = 1'b1;
            if (written_a[req.table_index]) usable_bytes.push_back(req.table_index);
          end
        end else if (!written_a[req.table_index]) begin
          written_a[req.table_index] = 1'b1;
          if (written_b[req.table_index]) usable_bytes.push_back(req.table_index);
        end
      end
      OP_CLEAR: fed_bytes.delete();
      OP_FEED: fed_bytes.push_back(req.add_byte);
      OP_ROLL: begin
        if (!predicted.status) fed_bytes.push_back(req.add_byte);
      end
    endcase
    if (fed_bytes.size() > 160) void'(fed_bytes.pop_front());
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 16 : 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
                                                : $urandom_range(1, 12);
    end
  endtask

  task automatic send_table_writes(input int n);
    in_t r;
    int  base;
    bit  found;
    repeat (n) begin
      r = rand_req(OP_WRITE);
      if ($urandom_range(0, 1)) begin
        // aim at an entry not yet written so more bytes become usable
        base = $urandom_range(0, 255);
        found = 1'b0;
        for (int k = 0; k < ENTRIES && !found; k++) begin
          if (!(r.table_select ? written_b[(base + k) % ENTRIES]
                               : written_a[(base + k) % ENTRIES])) begin
            r.table_index = 8'((base + k) % ENTRIES);
            found = 1'b1;
          end
        end
      end
      send_request(r, 1'b0, '0);
    end
  endtask

  // optionally clear, feed bytes (usually enough to fill the window), then roll along the stream
  task automatic send_window_run();
    in_t r;
    int  feeds;
    int  rolls;
    if ($urandom_range(0, 3) != 0) send_request(rand_req(OP_CLEAR), 1'b0, '0);
    feeds = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cfg_window)
                                         : cfg_window + $urandom_range(0, 3);
    rolls = $urandom_range(1, 24);
    repeat (feeds) send_request(rand_req(OP_FEED), 1'b0, '0);
    repeat (rolls) begin
      r = rand_req(OP_ROLL);
      if (cfg_window != 0 && fed_bytes.size() >= cfg_window && $urandom_range(0, 3) != 0)
        r.remove_byte = fed_bytes[fed_bytes.size() - cfg_window];
      send_request(r, 1'b0, '0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] readback;
    logic [31:0] want;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    readback = cfg_prdata;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_WINDOW: begin
        cfg_window = val[WIN_W-1:0];
        want = {{(32 - WIN_W){1'b0}}, val[WIN_W-1:0]};
      end
      REG_STEP: begin
        cfg_step = val[ROT_W-1:0];
        want = {{(32 - ROT_W){1'b0}}, val[ROT_W-1:0]};
      end
      default: begin
        cfg_mask = val;
        want = val;
      end
    endcase
    if (readback !== want) log_mismatch("register readback", idx, readback, want);
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n) begin
      if (in_valid && !in_ready) input_stall_cycles++;
      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0) begin
          log_mismatch("result with no request pending", results_checked,
                       out_data.first_hash, '0);
        end else begin
          want = expected_hashes.pop_front();
          if (out_data.first_hash !== want.first_hash)
            log_mismatch("first_hash", results_checked, out_data.first_hash,
                         want.first_hash);
          if (out_data.second_hash !== want.second_hash)
            log_mismatch("second_hash", results_checked, out_data.second_hash,
                         want.second_hash);
          if (out_data.status !== want.status)
            log_mismatch("status", results_checked, 32'(out_data.status),
                         32'(want.status));
          if (want.status) early_rolls++;
          results_checked++;
        end
      end
    end
  end

  initial begin : drain_pattern
    drain_mode_e mode;
    int          mode_left;
    int          period;
    int          duty;
    int          tick;
    bit          held;
    mode = DRAIN_FREE;
    mode_left = 0;
    period = 2;
    duty = 1;
    tick = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (!held && requests_accepted >= HOLD_AT) begin
        // long hold-off: the block must back up and drop in_ready
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = drain_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 200);
          period = $urandom_range(2, 9);
          duty = $urandom_range(1, period - 1);
        end
        mode_left--;
        case (mode)
          DRAIN_FREE: out_ready <= 1'b1;
          DRAIN_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          DRAIN_PERIODIC: out_ready <= ((tick % period) < duty);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [WIN_W-1:0] phase_window [NUM_PHASES];
    logic [ROT_W-1:0] phase_step [NUM_PHASES];
    logic [31:0]      phase_mask [NUM_PHASES];
    int               phase_start;
    int               pick;
    phase_window = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd32, 7'd3,
                     7'($urandom_range(1, 64)), 7'($urandom_range(0, 127))};
    phase_step = '{5'd0, 5'd31, 5'd7, 5'd5, 5'd1, 5'd13,
                   5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))};
    phase_mask = '{32'hFFFF_FFFF, 32'h0, $urandom(), 32'hFFFF_0000, 32'hFFFF_FFFF,
                   $urandom(), 32'h0000_FFFF, $urandom()};

    // reset config: window 10, step 1, full mask
    add_row(OP_WRITE, 1'b0, 8'h00, 32'h0000_0000, 8'hFF, 8'h00, 1'b1, '0, '0, 1'b0);
    add_row(OP_WRITE, 1'b1, 8'h00, 32'hFFFF_FFFF, 8'h00, 8'hFF, 1'b1, '0, '0, 1'b0);
    add_row(OP_WRITE, 1'b0, 8'hFF, 32'hFFFF_FFFF, 8'h00, 8'h00, 1'b1, '0, '0, 1'b0);
    add_row(OP_WRITE, 1'b1, 8'hFF, 32'h0000_0001, 8'hFF, 8'hFF, 1'b1, '0, '0, 1'b0);
    add_row(OP_WRITE, 1'b0, 8'h5A, 32'hA5A5_5A5A, 8'h00, 8'h00, 1'b1, '0, '0, 1'b0);
    add_row(OP_WRITE, 1'b1, 8'h5A, 32'h1234_5678, 8'h00, 8'h00, 1'b1, '0, '0, 1'b0);
    add_row(OP_CLEAR, 1'b1, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, '0, '0, 1'b0);
    // roll before the window has filled
    add_row(OP_ROLL,  1'b0, 8'h00, 32'h0,         8'hFF, 8'h00, 1'b1, '0, '0, 1'b1);
    add_row(OP_FEED,  1'b0, 8'h00, 32'h0,         8'h00, 8'h00, 1'b1,
            32'h0, 32'hFFFF_FFFF, 1'b0);
    add_row(OP_FEED,  1'b0, 8'h00, 32'h0,         8'hFF, 8'h00, 1'b0, '0, '0, 1'b0);
    add_row(OP_FEED,  1'b0, 8'h00, 32'h0,         8'h5A, 8'h00, 1'b0, '0, '0, 1'b0);
    add_row(OP_FEED,  1'b0, 8'h00, 32'h0,         8'h00, 8'h00, 1'b0, '0, '0, 1'b0);
    add_row(OP_FEED,  1'b0, 8'h00, 32'h0,         8'hFF, 8'h00, 1'b0, '0, '0, 1'b0);
    add_row(OP_FEED,  1'b0, 8'h00, 32'h0,         8'h5A, 8'h00, 1'b0, '0, '0, 1'b0);
    add_row(OP_FEED,  1'b0, 8'h00, 32'h0,         8'hFF, 8'h00, 1'b0, '0, '0, 1'b0);
    add_row(OP_FEED,  1'b0, 8'h00, 32'h0,         8'h00, 8'h00, 1'b0, '0, '0, 1'b0);
    add_row(OP_FEED,  1'b0, 8'h00, 32'h0,         8'h5A, 8'h00, 1'b0, '0, '0, 1'b0);
    add_row(OP_FEED,  1'b0, 8'h00, 32'h0,         8'hFF, 8'h00, 1'b0, '0, '0, 1'b0);
    // window now full, rolls take effect
    add_row(OP_ROLL,  1'b0, 8'h00, 32'h0,         8'h5A, 8'h00, 1'b0, '0, '0, 1'b0);
    add_row(OP_ROLL,  1'b0, 8'h00, 32'h0,         8'hFF, 8'hFF, 1'b0, '0, '0, 1'b0);
    add_row(OP_ROLL,  1'b0, 8'h00, 32'h0,         8'h00, 8'h5A, 1'b0, '0, '0, 1'b0);
    add_row(OP_CLEAR, 1'b0, 8'h00, 32'h0,         8'h00, 8'h00, 1'b1, '0, '0, 1'b0);
    add_row(OP_FEED,  1'b0, 8'h00, 32'h0,         8'h5A, 8'h00, 1'b0, '0, '0, 1'b0);
    // write keeps the hashes; the next feed must see the new word
    add_row(OP_WRITE, 1'b0, 8'h5A, 32'h0000_0000, 8'h5A, 8'h00, 1'b1,
            32'hA5A5_5A5A, 32'h1234_5678, 1'b0);
    add_row(OP_FEED,  1'b0, 8'h00, 32'h0,         8'h5A, 8'h00, 1'b0, '0, '0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(REG_WINDOW, 32'(phase_window[p]));
      write_reg(REG_STEP, 32'(phase_step[p]));
      write_reg(REG_MASK, phase_mask[p]);
      phase_start = requests_accepted;
      while (requests_accepted - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
          send_table_writes($urandom_range(1, 12));
        end else if (pick < 82) begin
          send_window_run();
        end else begin
          repeat ($urandom_range(1, 8))
            send_request(rand_req(2'($urandom_range(0, 3))), 1'b0, '0);
        end
      end
    end
    settle();

    $display("run: %0d requests (%0d directed), %0d results checked, %0d early rolls",
             requests_accepted, directed_rows.size(), results_checked, early_rolls);
    $display("run: %0d config phases, %0d byte values hashable, %0d input stall cycles",
             NUM_PHASES, usable_bytes.size(), input_stall_cycles);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #3_200_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- dual_table_rolling_hash.f -----
+incdir+rtl/core
rtl/core/drh_pkg.sv
rtl/core/drh_cfg.sv
rtl/core/drh_table.sv
rtl/core/drh_lane.sv
rtl/core/dual_table_rolling_hash.sv
rtl/core/drh_checker.sv
tb/tb_dual_table_rolling_hash.sv
